@@ rtl/lru_page_order_queue_core_defines.svh @@
// ---------------------------------------------------------------------------
// LRU page order queue assertion macros
// Shared property shorthands for the checker.
// ---------------------------------------------------------------------------
`ifndef LRU_PAGE_ORDER_QUEUE_CORE_DEFINES_SVH
`define LRU_PAGE_ORDER_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LOPQ_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lopq assertion failed");

// next-cycle implication, disabled in reset
`define LOPQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lopq assertion failed");

`endif

@@ rtl/lopq_pkg.sv @@
// ---------------------------------------------------------------------------
// LRU page order queue package
// Sizes, entry layout and action and status codes.
// ---------------------------------------------------------------------------
package lopq_pkg;

  localparam int DEPTH   = 64;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int PAGE_W  = 20;
  localparam int PID_W   = 16;
  localparam int ACT_W   = 2;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 7;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_TOUCH = 2'd2
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic              dirty;
    logic [PID_W-1:0]  pid;
    logic [PAGE_W-1:0] page;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    entry_t            entry;
  } result_t;

endpackage

@@ rtl/lru_page_order_queue_core.sv @@
// ---------------------------------------------------------------------------
// LRU page order queue
// Entry memory held as a ring, oldest entry at the head pointer.
// ---------------------------------------------------------------------------
// One transaction is worked at a time and gives one result. Push, rejected
// actions and the unused action code go from idle through S_RESP to the
// output register; pop passes through S_POP first. A touch scans the ring
// through the single read port of the entry memory, one entry per cycle,
// and closes up the gap behind the match in the same pass. The next
// transaction is taken once the result has moved into the output register.
module lru_page_order_queue_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lopq_pkg::ACT_W-1:0]   action_i,
  input  logic [lopq_pkg::PAGE_W-1:0]  page_number_i,
  input  logic [lopq_pkg::PID_W-1:0]   process_id_i,
  input  logic                         dirty_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lopq_pkg::STAT_W-1:0]  status_o,
  output logic [lopq_pkg::PAGE_W-1:0]  page_out_o,
  output logic [lopq_pkg::PID_W-1:0]   pid_out_o,
  output logic                         dirty_out_o,
  output logic [lopq_pkg::OCC_W-1:0]   occupancy_o
);
  import lopq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_PLACE,
    S_RESP
  } state_e;

  function automatic logic [PTR_W-1:0] ring_addr(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] pos);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, pos};
    if (sum >= (PTR_W+1)'(DEPTH)) begin
      sum = sum - (PTR_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  entry_t mem_q [DEPTH];

  state_e            state_q, state_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  rd_k_q, rd_k_d;
  logic [PTR_W-1:0]  dk_q, dk_d;
  logic              dv_q, dv_d;
  logic              found_q, found_d;
  entry_t            key_q, key_d;
  entry_t            keep_q, keep_d;
  result_t           res_q, res_d;
  result_t           out_q, out_d;
  logic [OCC_W-1:0]  out_occ_q, out_occ_d;
  logic              out_valid_q, out_valid_d;

  entry_t            rd_data_q;
  logic [PTR_W-1:0]  rd_addr;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  entry_t            wr_data;

  logic              accept;
  logic              hit;
  logic              last;
  logic [CNT_W-1:0]  last_pos;
  logic              out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign hit      = (rd_data_q == key_q);
  assign last_pos = count_q - CNT_W'(1);
  assign last     = ({{(CNT_W-PTR_W){1'b0}}, dk_q} == last_pos);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    rd_k_d      = rd_k_q;
    dk_d        = dk_q;
    dv_d        = 1'b0;
    found_d     = found_q;
    key_d       = key_q;
    keep_d      = keep_q;
    res_d       = res_q;
    out_d       = out_q;
    out_occ_d   = out_occ_q;
    out_valid_d = out_valid_q;
    rd_addr     = head_q;
    wr_en       = 1'b0;
    wr_addr     = head_q;
    wr_data     = key_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d = '{dirty: dirty_in_i, pid: process_id_i, page: page_number_i};
          res_d = '0;
          state_d = S_RESP;
          case (action_i)
            ACT_PUSH: begin
              if (count_q == CNT_W'(DEPTH)) begin
                res_d.status = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = ring_addr(head_q, count_q[PTR_W-1:0]);
                wr_data = '{dirty: dirty_in_i, pid: process_id_i, page: page_number_i};
                count_d = count_q + CNT_W'(1);
              end
            end
            ACT_POP: begin
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                state_d = S_POP;
              end
            end
            ACT_TOUCH: begin
              if (count_q == '0) begin
                res_d.status = ST_NOT_FOUND;
              end else begin
                rd_k_d  = CNT_W'(1);
                dk_d    = '0;
                dv_d    = 1'b1;
                found_d = 1'b0;
                state_d = S_SCAN;
              end
            end
            default: res_d.status = ST_OK;
          endcase
        end
      end
      S_POP: begin
        res_d.entry = rd_data_q;
        head_d      = ring_addr(head_q, PTR_W'(1));
        count_d     = count_q - CNT_W'(1);
        state_d     = S_RESP;
      end
      S_SCAN: begin
        rd_addr = ring_addr(head_q, rd_k_q[PTR_W-1:0]);
        if (rd_k_q < count_q) begin
          rd_k_d = rd_k_q + CNT_W'(1);
          dk_d   = rd_k_q[PTR_W-1:0];
          dv_d   = 1'b1;
        end
        if (dv_q) begin
          if (found_q) begin
            wr_en   = 1'b1;
            wr_addr = ring_addr(head_q, dk_q - PTR_W'(1));
            wr_data = rd_data_q;
          end else if (hit) begin
            found_d = 1'b1;
            keep_d  = rd_data_q;
          end
          if (last) begin
            dv_d = 1'b0;
            if (found_q) begin
              state_d = S_PLACE;
            end else begin
              res_d.status = hit ? ST_OK : ST_NOT_FOUND;
              state_d      = S_RESP;
            end
          end
        end
      end
      S_PLACE: begin
        wr_en        = 1'b1;
        wr_addr      = ring_addr(head_q, last_pos[PTR_W-1:0]);
        wr_data      = keep_q;
        res_d.status = ST_OK;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_occ_d   = OCC_W'(count_q);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      rd_k_q      <= '0;
      dk_q        <= '0;
      dv_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      rd_k_q      <= rd_k_d;
      dk_q        <= dk_d;
      dv_q        <= dv_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    keep_q    <= keep_d;
    res_q     <= res_d;
    out_q     <= out_d;
    out_occ_q <= out_occ_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign page_out_o  = out_q.entry.page;
  assign pid_out_o   = out_q.entry.pid;
  assign dirty_out_o = out_q.entry.dirty;
  assign occupancy_o = out_occ_q;

endmodule

@@ rtl/lopq_checker.sv @@
// ---------------------------------------------------------------------------
// LRU page order queue checker
// Port-level properties, bound to the queue top level.
// ---------------------------------------------------------------------------
`include "lru_page_order_queue_core_defines.svh"

module lopq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [lopq_pkg::STAT_W-1:0]  status_o,
  input logic [lopq_pkg::PAGE_W-1:0]  page_out_o,
  input logic [lopq_pkg::PID_W-1:0]   pid_out_o,
  input logic                         dirty_out_o,
  input logic [lopq_pkg::OCC_W-1:0]   occupancy_o
);
  import lopq_pkg::*;

  // held result stays put while stalled
  `LOPQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(status_o) && $stable(page_out_o) && $stable(occupancy_o))

  // one transaction in flight at a time
  `LOPQ_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  `LOPQ_ASSERT_NOW(a_occ_bound, clk_i, rst_ni, out_valid_o, occupancy_o <= OCC_W'(DEPTH))

  `LOPQ_ASSERT_NOW(a_reject_occ, clk_i, rst_ni,
    out_valid_o && (status_o == ST_FULL || status_o == ST_EMPTY),
    (status_o == ST_FULL) ? (occupancy_o == OCC_W'(DEPTH)) : (occupancy_o == '0))

  // only a good pop carries an entry
  `LOPQ_ASSERT_NOW(a_zero_payload, clk_i, rst_ni, out_valid_o && status_o != ST_OK,
    page_out_o == '0 && pid_out_o == '0 && !dirty_out_o)

endmodule

bind lru_page_order_queue_core lopq_checker u_lopq_checker (.*);
